[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the zigzag block bit-packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define ZBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ZBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/zbb_pkg.sv]
// Package: constants, register indexes and helper functions of the bit-packer.
`default_nettype none

package zbb_pkg;

  localparam int unsigned MaxRows     = 16;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned StoreDepth  = MaxRows * MaxChannels;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned CountW      = $clog2(StoreDepth + 1);
  localparam int unsigned ValW        = 16;
  localparam int unsigned BwW         = 5;
  localparam int unsigned AccW        = 48;  // one word plus one value of spill
  localparam int unsigned BitsW       = 6;

  // Configuration register indexes
  localparam logic [1:0] CfgRows     = 2'd0;
  localparam logic [1:0] CfgChannels = 2'd1;
  localparam logic [1:0] CfgCapacity = 2'd2;

  // Zigzag map: sign folded into bit 0
  function automatic logic [ValW-1:0] zigzag(input logic [ValW-1:0] x);
    zigzag = {x[ValW-2:0], 1'b0} ^ {ValW{x[ValW-1]}};
  endfunction

  // Bits needed to hold v (0 for zero)
  function automatic logic [BwW-1:0] width_of(input logic [ValW-1:0] v);
    logic [BwW-1:0] w;
    w = '0;
    for (int i = 0; i < ValW; i++) begin
      if (v[i]) w = BwW'(i + 1);
    end
    width_of = w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/zbb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module zbb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/zigzag_block_bitpacker.sv]
// Top level: zigzag block bit-packer with buffered block and packed word output.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_stall_o | error_value_i
//  out     | output    | out_valid_o/out_stall_i | packed_word_o valid_bytes_o last_word_o
//          |           |                      | overflow_o
//  cfg     | input     | cfg_we_i             | cfg_idx_i cfg_wdata_i
//
// Loading takes one item per cycle while in_stall_o is low; each mapped
// value goes to the block RAM. After the last item the block is sized in
// ST_HEAD, then each value is read (ST_RD) and appended (ST_APP); ST_RD sends words.
// Input is stalled from the last item of a block until its final word enters the
// output register.
// Reset clears the control state; the payload registers and the RAM are not cleared.
// An output stall only holds the emit walk; the output register holds its word.
`default_nettype none
`include "assert_macros.svh"

module zigzag_block_bitpacker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [15:0] error_value_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      packed_word_o,
  output logic [2:0]       valid_bytes_o,
  output logic             last_word_o,
  output logic             overflow_o
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_RD   = 4'b0100,
    ST_APP  = 4'b1000
  } state_e;

  localparam int unsigned AddrW  = zbb_pkg::AddrW;
  localparam int unsigned CountW = zbb_pkg::CountW;
  localparam int unsigned ValW   = zbb_pkg::ValW;
  localparam int unsigned BwW    = zbb_pkg::BwW;
  localparam int unsigned AccW   = zbb_pkg::AccW;
  localparam int unsigned BitsW  = zbb_pkg::BitsW;

  state_e              state_q, state_d;
  logic [4:0]          rows_q, rows_d;
  logic [2:0]          chans_q, chans_d;
  logic [7:0]          cap_q, cap_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [ValW-1:0]     max_q, max_d;
  logic [CountW-1:0]   rd_idx_q, rd_idx_d;
  logic [BwW-1:0]      bw_q, bw_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [BitsW-1:0]    bits_q, bits_d;

  logic                out_valid_q, out_valid_d;
  logic [31:0]         word_q, word_d;
  logic [2:0]          vbytes_q, vbytes_d;
  logic                last_q, last_d;
  logic                ovf_q, ovf_d;

  logic [4:0]          rows_eff;
  logic [2:0]          chans_eff;
  logic [CountW-1:0]   blk_len;
  logic [ValW-1:0]     mapped;
  logic                in_xfer;
  logic                out_free;
  logic                out_push;
  logic [BwW-1:0]      bw_new;
  logic [15:0]         hdr;
  logic [10:0]         payload_bits;
  logic [8:0]          total_bytes;
  logic                ram_re;
  logic [ValW-1:0]     ram_rdata;

  // Effective geometry, clamped to the supported range
  always_comb begin
    rows_eff = rows_q;
    if (rows_q == 5'd0) rows_eff = 5'd1;
    else if (rows_q > 5'(zbb_pkg::MaxRows)) rows_eff = 5'(zbb_pkg::MaxRows);
    chans_eff = chans_q;
    if (chans_q == 3'd0) chans_eff = 3'd1;
    else if (chans_q > 3'(zbb_pkg::MaxChannels)) chans_eff = 3'(zbb_pkg::MaxChannels);
  end
  assign blk_len = CountW'(rows_eff * chans_eff);

  assign mapped   = zbb_pkg::zigzag(error_value_i);
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Block sizing from the final maximum
  assign bw_new       = zbb_pkg::width_of(max_q);
  assign hdr          = {3'b000, rows_eff, 3'b000, bw_new};
  assign payload_bits = 11'(count_q * bw_new);
  assign total_bytes  = 9'd2 + 9'((payload_bits + 11'd7) >> 3);

  // Block store: written while loading, read while emitting (never both at once)
  zbb_ram #(
    .Width(ValW),
    .Depth(zbb_pkg::StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(mapped),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Control and datapath
  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    chans_d     = chans_q;
    cap_d       = cap_q;
    count_d     = count_q;
    max_d       = max_q;
    rd_idx_d    = rd_idx_q;
    bw_d        = bw_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    vbytes_d    = vbytes_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    out_push    = 1'b0;
    ram_re      = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          count_d = count_q + CountW'(1);
          if (mapped > max_q) max_d = mapped;
          if (count_q + CountW'(1) >= blk_len) state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        bw_d   = bw_new;
        acc_d  = AccW'(hdr);
        bits_d = BitsW'(16);
        rd_idx_d = '0;
        if (cap_q < 8'd2 || bw_new == '0 || total_bytes > 9'(cap_q)) begin
          // header-only or empty result
          if (out_free) begin
            out_push = 1'b1;
            last_d   = 1'b1;
            if (cap_q < 8'd2) begin
              word_d   = '0;
              vbytes_d = 3'd0;
              ovf_d    = 1'b1;
            end else begin
              word_d   = 32'(hdr);
              vbytes_d = 3'd2;
              ovf_d    = (bw_new != '0);
            end
            count_d = '0;
            max_d   = '0;
            state_d = ST_LOAD;
          end
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (bits_q >= BitsW'(32) && (rd_idx_q < count_q || bits_q > BitsW'(32))) begin
          // full word, more follows
          if (out_free) begin
            out_push = 1'b1;
            word_d   = acc_q[31:0];
            vbytes_d = 3'd4;
            last_d   = 1'b0;
            ovf_d    = 1'b0;
            acc_d    = acc_q >> 32;
            bits_d   = bits_q - BitsW'(32);
          end
        end else if (rd_idx_q < count_q) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + CountW'(1);
          state_d  = ST_APP;
        end else if (out_free) begin
          // final word
          out_push = 1'b1;
          word_d   = acc_q[31:0];
          vbytes_d = 3'((bits_q + BitsW'(7)) >> 3);
          last_d   = 1'b1;
          ovf_d    = 1'b0;
          count_d  = '0;
          max_d    = '0;
          state_d  = ST_LOAD;
        end
      end
      ST_APP: begin
        acc_d   = acc_q | (AccW'(ram_rdata) << bits_q);
        bits_d  = bits_q + BitsW'(bw_q);
        state_d = ST_RD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (out_push) out_valid_d = 1'b1;

    // Writes to the rows, channels or capacity register drop the block in progress
    if (cfg_we_i) begin
      case (cfg_idx_i)
        zbb_pkg::CfgRows: begin
          rows_d  = cfg_wdata_i[4:0];
          count_d = '0;
          max_d   = '0;
        end
        zbb_pkg::CfgChannels: begin
          chans_d = cfg_wdata_i[2:0];
          count_d = '0;
          max_d   = '0;
        end
        zbb_pkg::CfgCapacity: begin
          cap_d   = cfg_wdata_i;
          count_d = '0;
          max_d   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      rows_q      <= 5'd1;
      chans_q     <= 3'd1;
      cap_q       <= 8'd255;
      count_q     <= '0;
      max_q       <= '0;
      rd_idx_q    <= '0;
      bw_q        <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      chans_q     <= chans_d;
      cap_q       <= cap_d;
      count_q     <= count_d;
      max_q       <= max_d;
      rd_idx_q    <= rd_idx_d;
      bw_q        <= bw_d;
      bits_q      <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    word_q   <= word_d;
    vbytes_q <= vbytes_d;
    last_q   <= last_d;
    ovf_q    <= ovf_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = word_q;
  assign valid_bytes_o = vbytes_q;
  assign last_word_o   = last_q;
  assign overflow_o    = ovf_q;

  // Checks
  `ZBB_ASSERT(a_bits_range, bits_q < BitsW'(48), "bit accumulator overran")
  `ZBB_ASSERT_IMP(a_load_count, state_q == ST_LOAD, count_q < blk_len, "count past block")
  `ZBB_ASSERT_IMP(a_app_after_rd, state_q == ST_APP, $past(state_q) == ST_RD, "append without read")
  `ZBB_ASSERT_NEXT(a_last_clears, out_push && last_d, state_q == ST_LOAD && count_q == '0, "block not cleared")

endmodule

`default_nettype wire

[sim/zbb_stream_checker.sv]
// Checker for the zigzag block bit-packer: tracks config, predicts packed words, compares.
`timescale 1ns / 1ps

module zbb_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] error_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] packed_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  logic        overflow_i,
  output int          pending_o,
  output int          mismatches_o
);

  localparam int MaxWords = 33;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        ovf;
  } stream_word_t;

  stream_word_t expected_words[$];

  // shadow registers and block state
  logic [4:0]  rows_reg;
  logic [2:0]  chans_reg;
  logic [7:0]  cap_reg;
  logic [15:0] block_vals [zbb_pkg::StoreDepth];
  logic [15:0] peak;
  int          held;

  function automatic int rows_used();
    if (rows_reg == 0) return 1;
    if (rows_reg > zbb_pkg::MaxRows) return zbb_pkg::MaxRows;
    return int'(rows_reg);
  endfunction

  function automatic int chans_used();
    if (chans_reg == 0) return 1;
    if (chans_reg > zbb_pkg::MaxChannels) return zbb_pkg::MaxChannels;
    return int'(chans_reg);
  endfunction

  task automatic push_word(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic last, input logic ovf);
    stream_word_t w;
    w.word   = word;
    w.nbytes = nbytes;
    w.last   = last;
    w.ovf    = ovf;
    expected_words.push_back(w);
  endtask

  // Size the block; emit header and values four bytes a word if they fit, else overflow
  task automatic pack_block();
    logic [MaxWords*32-1:0] bits;
    logic [15:0]            v;
    logic [31:0]            hdr;
    int                     bw, rows, payload, total, nwords, pos, nb;
    rows = rows_used();
    bw = 0;
    v = peak;
    while (v != 0) begin
      bw++;
      v = v >> 1;
    end
    hdr = {16'h0, 8'(rows), 8'(bw)};
    payload = (held * bw + 7) / 8;
    if (cap_reg < 2) begin
      push_word(32'h0, 3'd0, 1'b1, 1'b1);
    end else if (bw == 0) begin
      push_word(hdr, 3'd2, 1'b1, 1'b0);
    end else if (2 + payload > int'(cap_reg)) begin
      push_word(hdr, 3'd2, 1'b1, 1'b1);
    end else begin
      bits = '0;
      bits[15:0] = hdr[15:0];
      pos = 16;
      for (int i = 0; i < held; i++) begin
        for (int b = 0; b < bw; b++) begin
          bits[pos] = block_vals[i][b];
          pos++;
        end
      end
      total = 2 + payload;
      nwords = (total + 3) / 4;
      for (int k = 0; k < nwords; k++) begin
        nb = total - 4 * k;
        if (nb > 4) nb = 4;
        push_word(bits[32*k +: 32], 3'(nb), k == nwords - 1, 1'b0);
      end
    end
    held = 0;
    peak = '0;
  endtask

  // One error value in: zigzag map, store, track the peak, pack when the block is full
  task automatic absorb_error(input logic [15:0] x);
    logic [15:0] m;
    m = x[15] ? ~(x << 1) : (x << 1);
    if (held < zbb_pkg::StoreDepth) begin
      block_vals[held] = m;
      held++;
    end
    if (m > peak) peak = m;
    if (held >= rows_used() * chans_used()) pack_block();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    stream_word_t e;
    if (!rst_ni) begin
      rows_reg = 5'd1;
      chans_reg = 3'd1;
      cap_reg = 8'd255;
      held = 0;
      peak = '0;
      expected_words.delete();
      mismatches_o = 0;
    end else begin
      // result side first: an input taken at this edge cannot have produced it yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: unexpected word %h bytes %0d last %b ovf %b", $realtime,
                     packed_word_i, valid_bytes_i, last_word_i, overflow_i);
        end else begin
          e = expected_words.pop_front();
          if (packed_word_i !== e.word || valid_bytes_i !== e.nbytes ||
              last_word_i !== e.last || overflow_i !== e.ovf) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: mismatch, expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                       $realtime, e.word, e.nbytes, e.last, e.ovf,
                       packed_word_i, valid_bytes_i, last_word_i, overflow_i);
          end
        end
      end
      // a write to the rows, channels or capacity register drops the partial block
      if (cfg_we_i) begin
        case (cfg_idx_i)
          zbb_pkg::CfgRows: begin
            rows_reg = cfg_wdata_i[4:0];
            held = 0;
            peak = '0;
          end
          zbb_pkg::CfgChannels: begin
            chans_reg = cfg_wdata_i[2:0];
            held = 0;
            peak = '0;
          end
          zbb_pkg::CfgCapacity: begin
            cap_reg = cfg_wdata_i;
            held = 0;
            peak = '0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_error(error_value_i);
    end
    pending_o = expected_words.size();
  end

endmodule

[sim/zigzag_block_bitpacker_tb.sv]
// Testbench top for the zigzag block bit-packer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module zigzag_block_bitpacker_tb;

  localparam int SettleCycles  = 200;
  localparam int WatchdogLimit = 4000;
  localparam int RandomItems   = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = zbb_pkg::CfgRows;
  logic [7:0]  cfg_wdata_i = 8'h0;
  logic        in_valid_i = 1'b0;
  logic [15:0] error_value_i = 16'h0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] packed_word_o;
  logic [2:0]  valid_bytes_o;
  logic        last_word_o;
  logic        overflow_o;

  int pending_words;
  int mismatch_total;
  int random_items = 0;
  int stall_hold;
  int idle_cycles;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  always #4 clk_i = ~clk_i;

  zigzag_block_bitpacker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .error_value_i (error_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_word_o (packed_word_o),
    .valid_bytes_o (valid_bytes_o),
    .last_word_o   (last_word_o),
    .overflow_o    (overflow_o)
  );

  zbb_stream_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .error_value_i (error_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_word_i (packed_word_o),
    .valid_bytes_i (valid_bytes_o),
    .last_word_i   (last_word_o),
    .overflow_i    (overflow_o),
    .pending_o     (pending_words),
    .mismatches_o  (mismatch_total)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // inverse zigzag, so a chosen mapped value comes back out of the block
  function automatic logic [15:0] unfold(input logic [15:0] m);
    return m[0] ? ~{1'b0, m[15:1]} : {1'b0, m[15:1]};
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : stall_gen
    int g;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold <= 0;
    end else if (rx_quiet) begin
      out_stall_i <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      g = pick_gap();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        stall_hold <= g - 1;
      end else begin
        stall_hold <= $urandom_range(0, 6);
      end
    end
  end

  // Watchdog: cycles without any transfer or register write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid stays high between back-to-back transfers
  task automatic send_error(input logic [15:0] v);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    error_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every expected word, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One random configuration and a few blocks under it
  task automatic run_phase(input bit go_big);
    int          rows_v, chans_v, eff_r, eff_c, span, width, cap_v, nblk, hot, r, partial;
    logic [15:0] m;
    settle();
    if (go_big) begin
      rows_v = $urandom_range(0, 1) ? 16 : $urandom_range(17, 31);
      chans_v = $urandom_range(0, 1) ? 4 : $urandom_range(5, 7);
      width = 16;
    end else begin
      r = $urandom_range(0, 99);
      rows_v = r < 10 ? 0 : r < 80 ? $urandom_range(1, 4) :
               r < 92 ? $urandom_range(5, 16) : $urandom_range(17, 31);
      r = $urandom_range(0, 99);
      chans_v = r < 10 ? 0 : r < 75 ? $urandom_range(1, 2) :
                r < 90 ? $urandom_range(3, 4) : $urandom_range(5, 7);
      width = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16);
    end
    eff_r = rows_v == 0 ? 1 : rows_v > 16 ? 16 : rows_v;
    eff_c = chans_v == 0 ? 1 : chans_v > 4 ? 4 : chans_v;
    span = eff_r * eff_c;
    r = $urandom_range(0, 99);
    if (go_big) cap_v = 255;
    else if (r < 8) cap_v = $urandom_range(0, 1);
    else if (r < 22) cap_v = $urandom_range(2, 12);
    else if (r < 40) cap_v = 2 + (span * width + 7) / 8 - $urandom_range(0, 1);
    else if (r < 70) cap_v = 255;
    else cap_v = $urandom_range(2, 255);
    write_reg(zbb_pkg::CfgRows, {3'($urandom), 5'(rows_v)});
    write_reg(zbb_pkg::CfgChannels, {5'($urandom), 3'(chans_v)});
    write_reg(zbb_pkg::CfgCapacity, 8'(cap_v));
    tx_quiet = ($urandom_range(0, 4) == 0);
    rx_quiet <= ($urandom_range(0, 4) == 0);
    nblk = go_big ? 1 : $urandom_range(1, 3);
    for (int blk = 0; blk < nblk; blk++) begin
      // one value per block carries the top bit, so the width is exactly as chosen
      hot = $urandom_range(0, span - 1);
      for (int i = 0; i < span; i++) begin
        m = width == 0 ? 16'h0 : 16'($urandom & ((1 << width) - 1));
        if (i == hot && width > 0) m[width-1] = 1'b1;
        send_error(unfold(m));
        random_items++;
      end
    end
    // broken block, dropped by the next register write
    if (!go_big && span > 1 && $urandom_range(0, 5) == 0) begin
      partial = $urandom_range(1, span - 1);
      repeat (partial) send_error(16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config (one row, one channel): zero width, both extremes, small values
    send_error(16'h0000);
    send_error(16'h8000);
    send_error(16'h7FFF);
    send_error(16'hFFFF);
    send_error(16'h0001);

    // Register write in the middle of a block drops the partial block
    settle();
    write_reg(zbb_pkg::CfgRows, 8'h03);
    write_reg(zbb_pkg::CfgChannels, 8'h01);
    write_reg(zbb_pkg::CfgCapacity, 8'hFF);
    send_error(16'h0123);
    settle();
    write_reg(zbb_pkg::CfgChannels, 8'h02);
    send_error(16'h0005);
    send_error(16'hFFF0);
    send_error(16'h0000);
    send_error(16'h7FFF);
    send_error(16'h8000);
    send_error(16'h0042);

    // Zero rows and channels act as one; capacity one, then zero
    settle();
    write_reg(zbb_pkg::CfgRows, 8'hE0);
    write_reg(zbb_pkg::CfgChannels, 8'hF8);
    write_reg(zbb_pkg::CfgCapacity, 8'h01);
    send_error(16'h1234);
    settle();
    write_reg(zbb_pkg::CfgCapacity, 8'h00);
    send_error(16'h0000);

    // Channels above the maximum clamp to four; payload too big for capacity
    settle();
    write_reg(zbb_pkg::CfgChannels, 8'hFF);
    write_reg(zbb_pkg::CfgCapacity, 8'h03);
    send_error(16'h8000);
    send_error(16'h0001);
    send_error(16'hFFFE);
    send_error(16'h7FFF);

    // Capacity boundary: exact fit, then one byte short
    settle();
    write_reg(zbb_pkg::CfgRows, 8'h02);
    write_reg(zbb_pkg::CfgChannels, 8'h01);
    write_reg(zbb_pkg::CfgCapacity, 8'h06);
    send_error(16'h8000);
    send_error(16'h1111);
    settle();
    write_reg(zbb_pkg::CfgCapacity, 8'h05);
    send_error(16'h8000);
    send_error(16'h1111);

    // Random phases: one maximum-size block first, then mostly small ones
    run_phase(1'b1);
    while (random_items < RandomItems) run_phase(1'b0);

    settle();
    if (mismatch_total == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/zbb_pkg.sv
rtl/core/zbb_ram.sv
rtl/core/zigzag_block_bitpacker.sv
sim/zbb_stream_checker.sv
sim/zigzag_block_bitpacker_tb.sv
